FILE: hw/rtl/pba_pkg.sv
// Shared types and constants for the paged bump allocator.
// Holds request/result payload structs, controller command/status structs
// and configuration register indexes. No dependencies.
package pba_pkg;

  // Default sizing of the page table and page offsets
  localparam int MAX_PAGES_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Configuration port shape
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_NUMBER   = 2'd2;

  // Configuration reset values
  localparam logic [31:0] PAGE_BYTES_RST    = 32'd1048576;
  localparam logic [4:0]  INITIAL_PAGES_RST = 5'd2;
  localparam logic [7:0]  POOL_NUMBER_RST   = 8'd0;

  // Request command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Input request payload
  typedef struct packed {
    logic        cmd;
    logic [31:0] request_bytes;
    logic [2:0]  align_log2;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic        success;
    logic [3:0]  page_number;
    logic [31:0] region_offset;
    logic [31:0] region_bytes;
    logic [7:0]  pool_tag;
  } out_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;   // capture accepted request
    logic idx_clr;    // restart the page scan at page 0
    logic idx_inc;    // move the scan to the next page
    logic wr_hit;     // grant in the scanned page
    logic wr_grow;    // activate a new page and grant there
    logic clr_fill;   // clear every page offset
    logic res_zero;   // issue an all-zero result
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_is_rst;  // request at the input is an offset reset
    logic fit;        // aligned request fits the scanned page
    logic last_page;  // scanned page is the last active one
    logic can_grow;   // a new page may be activated for this request
    logic out_free;   // result register can take a new result
  } ctl_sts_t;

endpackage

FILE: hw/rtl/pba_dp.sv
// Datapath of the paged bump allocator: configuration registers, page offset
// memory with valid bits, fit test, page growth and the result register.
// Depends on pba_pkg.
module pba_dp #(
  parameter int MAX_PAGES   = pba_pkg::MAX_PAGES_DEF,
  parameter int OFFSET_BITS = pba_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pba_pkg::in_req_t               in_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output pba_pkg::out_res_t              out_data,
  input  logic                           cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  pba_pkg::ctl_cmd_t              cmd,
  output pba_pkg::ctl_sts_t              sts
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int CW    = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam int AW    = CW + 2;

  // Clamp a requested page count to 1..MAX_PAGES
  function automatic logic [CNT_W-1:0] clamp_pages(input logic [4:0] v);
    logic [CNT_W-1:0] r;
    if (v == 5'd0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_PAGES) begin
      r = CNT_W'(MAX_PAGES);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  // Configuration and allocator state
  logic [31:0]            page_bytes_r;
  logic [7:0]             pool_r;
  logic [CNT_W-1:0]       active_r;
  logic [MAX_PAGES-1:0]   valid_r;
  logic [MAX_PAGES-1:0]   valid_nxt;
  logic [CNT_W-1:0]       cfg_active;

  // Captured request and scan index
  logic                   req_cmd_r;
  logic [31:0]            req_bytes_r;
  logic [2:0]             req_align_r;
  logic [IDX_W-1:0]       idx_r;

  // Page offset memory and its registered read
  logic [OFFSET_BITS-1:0] fill_mem [MAX_PAGES];
  logic [OFFSET_BITS-1:0] rd_data_r;
  logic                   rd_vld_r;

  // Fit test
  logic [OFFSET_BITS-1:0] fill_eff;
  logic [7:0]             amask;
  logic [AW-1:0]          aligned;
  logic [AW-1:0]          end_sum;
  logic [CW-1:0]          lim_ext;
  logic [CW-1:0]          pb_ext;
  logic [CW-1:0]          cap_w;

  // Memory write port
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [OFFSET_BITS-1:0] wr_data;

  // Result register
  logic                   out_valid_r;
  pba_pkg::out_res_t      out_data_r;
  logic                   res_load;
  pba_pkg::out_res_t      res_nxt;

  assign cfg_active = clamp_pages(cfg_wdata[4:0]);

  // Cap the page capacity at the largest representable offset
  always_comb begin
    lim_ext = CW'({OFFSET_BITS{1'b1}});
    pb_ext  = CW'(page_bytes_r);
    cap_w   = (pb_ext > lim_ext) ? lim_ext : pb_ext;
  end

  // Round the scanned offset up to the alignment and test the end of region
  always_comb begin
    fill_eff = rd_vld_r ? rd_data_r : '0;
    amask    = 8'((9'd1 << req_align_r) - 9'd1);
    aligned  = (AW'(fill_eff) + AW'(amask)) & ~AW'(amask);
    end_sum  = aligned + AW'(req_bytes_r);
  end

  always_comb begin
    sts.in_is_rst = (in_data.cmd == pba_pkg::CMD_RESET);
    sts.fit       = (req_cmd_r == pba_pkg::CMD_ALLOC) && (end_sum <= AW'(cap_w));
    sts.last_page = ((CNT_W'(idx_r) + CNT_W'(1)) == active_r);
    sts.can_grow  = (active_r < CNT_W'(MAX_PAGES)) && (CW'(req_bytes_r) <= cap_w);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // Configuration registers and active page count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r <= pba_pkg::PAGE_BYTES_RST;
      pool_r       <= pba_pkg::POOL_NUMBER_RST;
      active_r     <= clamp_pages(pba_pkg::INITIAL_PAGES_RST);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pba_pkg::CFG_PAGE_BYTES:    page_bytes_r <= cfg_wdata[31:0];
          pba_pkg::CFG_INITIAL_PAGES: active_r     <= cfg_active;
          pba_pkg::CFG_POOL_NUMBER:   pool_r       <= cfg_wdata[7:0];
          default: ;
        endcase
      end else if (cmd.wr_grow) begin
        active_r <= active_r + CNT_W'(1);
      end
    end
  end

  // Valid bits: an invalid page reads as offset zero
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.clr_fill) begin
      valid_nxt = '0;
    end else if (cfg_we && (cfg_index == pba_pkg::CFG_INITIAL_PAGES)) begin
      for (int i = 0; i < MAX_PAGES; i++) begin
        if (32'(i) >= 32'(cfg_active)) valid_nxt[i] = 1'b0;
      end
    end else if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the request and step the scan index
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_cmd_r   <= in_data.cmd;
      req_bytes_r <= in_data.request_bytes;
      req_align_r <= in_data.align_log2;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Memory write: bump the hit page, or seed a freshly activated page
  always_comb begin
    wr_en   = cmd.wr_hit || cmd.wr_grow;
    wr_addr = cmd.wr_grow ? IDX_W'(active_r) : idx_r;
    wr_data = cmd.wr_grow ? OFFSET_BITS'(req_bytes_r) : OFFSET_BITS'(end_sum);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fill_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= fill_mem[idx_r];
    rd_vld_r  <= valid_r[idx_r];
  end

  // Assemble the result
  always_comb begin
    res_load = cmd.wr_hit || cmd.wr_grow || cmd.res_zero;
    res_nxt  = '0;
    if (cmd.wr_hit) begin
      res_nxt.success       = 1'b1;
      res_nxt.page_number   = 4'(idx_r);
      res_nxt.region_offset = 32'(aligned);
      res_nxt.region_bytes  = req_bytes_r;
      res_nxt.pool_tag      = pool_r;
    end else if (cmd.wr_grow) begin
      res_nxt.success       = 1'b1;
      res_nxt.page_number   = 4'(active_r);
      res_nxt.region_offset = '0;
      res_nxt.region_bytes  = req_bytes_r;
      res_nxt.pool_tag      = pool_r;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Active page count stays within 1..MAX_PAGES
  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r >= CNT_W'(1)) && (active_r <= CNT_W'(MAX_PAGES)))
    else $error("active page count out of range");

  // A granted page leaves a pending result behind
  a_grant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_hit || cmd.wr_grow) |=> (out_valid_r && out_data_r.success))
    else $error("grant without a successful result");

endmodule

FILE: hw/rtl/pba_ctrl.sv
// Controller of the paged bump allocator: sequences the page scan, growth,
// offset reset and result hand-off. Depends on pba_pkg.
module pba_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pba_pkg::ctl_sts_t     sts,
  output pba_pkg::ctl_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_TEST = 4'b0100,
    S_RST  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = sts.in_is_rst ? S_RST : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (!sts.fit && !sts.last_page) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_READ;
        end else if (sts.out_free) begin
          if (sts.fit) begin
            cmd.wr_hit = 1'b1;
          end else if (sts.can_grow) begin
            cmd.wr_grow = 1'b1;
          end else begin
            cmd.res_zero = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_RST: begin
        if (sts.out_free) begin
          cmd.clr_fill = 1'b1;
          cmd.res_zero = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Grants only where the scanned page fits, growth only after a full miss
  a_hit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_hit |-> (sts.fit && sts.out_free && !cmd.wr_grow))
    else $error("grant issued without a fit");

  a_grow_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_grow |-> (!sts.fit && sts.last_page && sts.can_grow))
    else $error("page activated before the scan missed");

  // An accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted but controller stayed idle");

endmodule

FILE: hw/rtl/paged_bump_allocator.sv
// Paged bump allocator. An offset reset request clears all page offsets and
// returns an all-zero result; an allocation scans the active pages in turn
// (registered offset memory read, then align and fit test) and grants in the
// first page that fits, else grows by a new page or fails. No new request is
// taken until the last result is loaded. Synchronous reset restores the
// configuration defaults and clears all page offsets at once.
module paged_bump_allocator #(
  parameter int MAX_PAGES   = pba_pkg::MAX_PAGES_DEF,
  parameter int OFFSET_BITS = pba_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pba_pkg::in_req_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pba_pkg::out_res_t              out_data,
  input  logic                           cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pba_pkg::ctl_cmd_t cmd;
  pba_pkg::ctl_sts_t sts;

  // Sequencer
  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Page state, arithmetic and result register
  pba_dp #(
    .MAX_PAGES   (MAX_PAGES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
